// File: rtl/core/soinv_pkg.sv
package soinv_pkg;

    // Width of the arithmetic on the modulus; the port fields stay 31 bits wide.
    localparam int PRIME_WIDTH = 31;
    localparam int FIELD_WIDTH = 31;
    localparam int EXP_WIDTH   = 31;
    localparam int K_WIDTH     = 64;
    localparam int CFG_WIDTH   = 64;

    // Bit stream of the serial multiplier: longest operand is the class base.
    localparam int BITS_WIDTH = K_WIDTH;
    localparam int LEN_WIDTH  = $clog2(BITS_WIDTH + 1);

    // Shift count of the divider alignment: at most PRIME_WIDTH - 1 positions.
    localparam int SH_WIDTH = $clog2(PRIME_WIDTH);

    // Number of residue classes and the step between neighbouring sieve bits.
    localparam int CLASS_COUNT = 4 * 3 * 5 * 7 * 11 * 13;
    localparam int STEP_CONST  = 2 * CLASS_COUNT;
    localparam int STEP_WIDTH  = $clog2(STEP_CONST + 1);

    // The step constant, left-aligned in the serial bit stream.
    localparam logic [BITS_WIDTH-1:0] STEP_BITS =
        BITS_WIDTH'(STEP_CONST) << (BITS_WIDTH - STEP_WIDTH);

    typedef enum logic {
        REG_EXPONENT   = 1'b0,
        REG_CLASS_BASE = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRED,
        ST_NRED,
        ST_EUC,
        ST_KRED,
        ST_QMUL,
        ST_QFIX,
        ST_OMUL,
        ST_DONE
    } top_state_t;

    typedef enum logic [2:0] {
        EU_IDLE,
        EU_CHECK,
        EU_ALIGN,
        EU_SUB,
        EU_UPDATE,
        EU_FINAL
    } eu_state_t;

    typedef struct packed {
        logic                   start;
        logic [PRIME_WIDTH-1:0] mult;
        logic [BITS_WIDTH-1:0]  bits;
        logic [LEN_WIDTH-1:0]   len;
    } mm_req_t;

    typedef struct packed {
        logic                   done;
        logic [PRIME_WIDTH-1:0] res;
    } mm_rsp_t;

    typedef struct packed {
        logic                   start;
        logic [PRIME_WIDTH-1:0] n;
    } eu_req_t;

    typedef struct packed {
        logic                   done;
        logic                   ok;
        logic [PRIME_WIDTH-1:0] inv;
    } eu_rsp_t;

endpackage

// File: rtl/core/soinv_modmul.sv
// Bit-serial modular multiplier: res = (mult * bits) mod modulus, one bit of
// the multiplier stream per cycle, most significant bit first. The multiplicand
// must already be below the modulus; the stream may be 1 to BITS_WIDTH bits wide.
module soinv_modmul
    import soinv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mm_req_t                req,
    input  logic [PRIME_WIDTH-1:0] modulus,
    output mm_rsp_t                rsp
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [LEN_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [PRIME_WIDTH-1:0] acc_reg, acc_next;
    logic [PRIME_WIDTH-1:0] mult_reg, mult_next;
    logic [BITS_WIDTH-1:0]  bits_reg, bits_next;

    logic [PRIME_WIDTH+1:0] sum;
    logic [PRIME_WIDTH+1:0] mod_x;
    logic [PRIME_WIDTH+1:0] mod2_x;
    logic [PRIME_WIDTH-1:0] step_val;

    // Doubling plus an optional addend stays below three times the modulus.
    always_comb
    begin
        mod_x  = (PRIME_WIDTH + 2)'(modulus);
        mod2_x = (PRIME_WIDTH + 2)'({modulus, 1'b0});
        sum    = (PRIME_WIDTH + 2)'({acc_reg, 1'b0})
               + (bits_reg[BITS_WIDTH-1] ? (PRIME_WIDTH + 2)'(mult_reg) : '0);
        if (sum >= mod2_x)
        begin
            step_val = PRIME_WIDTH'(sum - mod2_x);
        end
        else if (sum >= mod_x)
        begin
            step_val = PRIME_WIDTH'(sum - mod_x);
        end
        else
        begin
            step_val = PRIME_WIDTH'(sum);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mult_next = mult_reg;
        bits_next = bits_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.len;
            acc_next  = '0;
            mult_next = req.mult;
            bits_next = req.bits;
        end
        else if (busy_reg)
        begin
            acc_next  = step_val;
            bits_next = bits_reg << 1;
            cnt_next  = cnt_reg - LEN_WIDTH'(1);
            if (cnt_reg == LEN_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        mult_reg <= mult_next;
        bits_reg <= bits_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = acc_reg;

`ifndef NO_ASSERTIONS
    // A finished product is fully reduced.
    a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (acc_reg < modulus || modulus == '0))
        else $error("modmul result not reduced");

    // The sequencer never restarts a unit that is still working.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("modmul started while busy");
`endif

endmodule

// File: rtl/core/soinv_euclid.sv
// Extended Euclidean algorithm with a radix-2 shift-subtract divider. Each
// quotient step first aligns the divisor one bit per cycle, then subtracts one
// bit per cycle while the product of quotient and coefficient builds up alongside.
module soinv_euclid
    import soinv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  eu_req_t                req,
    input  logic [PRIME_WIDTH-1:0] modulus,
    output eu_rsp_t                rsp
);

    eu_state_t state_reg, state_next;

    logic [PRIME_WIDTH-1:0]        rp_reg, rp_next;
    logic [PRIME_WIDTH-1:0]        rc_reg, rc_next;
    logic signed [PRIME_WIDTH:0]   tp_reg, tp_next;
    logic signed [PRIME_WIDTH:0]   tc_reg, tc_next;
    logic [PRIME_WIDTH-1:0]        rem_reg, rem_next;
    logic [PRIME_WIDTH-1:0]        div_reg, div_next;
    logic [SH_WIDTH-1:0]           sh_reg, sh_next;
    logic signed [PRIME_WIDTH+1:0] acc_reg, acc_next;

    logic                          fits;
    logic                          qbit;
    logic signed [PRIME_WIDTH+1:0] tdiff;
    logic signed [PRIME_WIDTH:0]   tp_plus;
    logic [PRIME_WIDTH-1:0]        inv_val;

    assign fits  = {div_reg, 1'b0} <= {1'b0, rem_reg};
    assign qbit  = rem_reg >= div_reg;
    assign tdiff = (PRIME_WIDTH + 2)'(tp_reg) - acc_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EU_IDLE:
            begin
                if (req.start)
                begin
                    state_next = EU_CHECK;
                end
            end
            EU_CHECK:
            begin
                state_next = (rc_reg == '0) ? EU_FINAL : EU_ALIGN;
            end
            EU_ALIGN:
            begin
                if (!fits)
                begin
                    state_next = EU_SUB;
                end
            end
            EU_SUB:
            begin
                if (sh_reg == '0)
                begin
                    state_next = EU_UPDATE;
                end
            end
            EU_UPDATE:
            begin
                state_next = EU_CHECK;
            end
            EU_FINAL:
            begin
                state_next = EU_IDLE;
            end
            default:
            begin
                state_next = EU_IDLE;
            end
        endcase
    end

    // The coefficient ends in (-m, m); fold it into [0, m).
    always_comb
    begin
        tp_plus = tp_reg + $signed({1'b0, modulus});
        if (tp_reg < 0)
        begin
            inv_val = tp_plus[PRIME_WIDTH-1:0];
        end
        else if (tp_reg[PRIME_WIDTH-1:0] >= modulus)
        begin
            inv_val = tp_reg[PRIME_WIDTH-1:0] - modulus;
        end
        else
        begin
            inv_val = tp_reg[PRIME_WIDTH-1:0];
        end
        rsp.done = (state_reg == EU_FINAL);
        rsp.ok   = (rp_reg == PRIME_WIDTH'(1));
        rsp.inv  = rsp.ok ? inv_val : '0;
    end

    always_comb
    begin
        rp_next  = rp_reg;
        rc_next  = rc_reg;
        tp_next  = tp_reg;
        tc_next  = tc_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        sh_next  = sh_reg;
        acc_next = acc_reg;
        case (state_reg)
            EU_IDLE:
            begin
                if (req.start)
                begin
                    rp_next = modulus;
                    rc_next = req.n;
                    tp_next = '0;
                    tc_next = (PRIME_WIDTH + 1)'(1);
                end
            end
            EU_CHECK:
            begin
                rem_next = rp_reg;
                div_next = rc_reg;
                sh_next  = '0;
                acc_next = '0;
            end
            EU_ALIGN:
            begin
                if (fits)
                begin
                    div_next = div_reg << 1;
                    sh_next  = sh_reg + SH_WIDTH'(1);
                end
            end
            EU_SUB:
            begin
                rem_next = qbit ? (rem_reg - div_reg) : rem_reg;
                acc_next = (acc_reg <<< 1)
                         + (qbit ? (PRIME_WIDTH + 2)'(tc_reg) : '0);
                div_next = div_reg >> 1;
                sh_next  = sh_reg - SH_WIDTH'(1);
            end
            EU_UPDATE:
            begin
                rp_next = rc_reg;
                rc_next = rem_reg;
                tp_next = tc_reg;
                tc_next = tdiff[PRIME_WIDTH:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EU_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg  <= rp_next;
        rc_reg  <= rc_next;
        tp_reg  <= tp_next;
        tc_reg  <= tc_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

`ifndef NO_ASSERTIONS
    // Remainders fall strictly at every quotient step.
    a_rem_falls: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == EU_CHECK |-> rc_reg < rp_reg)
        else $error("euclid remainder did not fall");

    // A returned inverse is reduced.
    a_inv_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.done && rsp.ok) |-> rsp.inv < modulus)
        else $error("euclid inverse not reduced");
`endif

endmodule

// File: rtl/core/sieve_offset_with_modular_inverse_top.sv
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_we                 cfg_index, cfg_data
// in       in         in_valid / in_stall    prime
// out      out        out_valid / out_stall  inverse, offset, no_inverse
//
// Items are taken one at a time. Their run time is set by the serial modular
// multiplier (one multiplier bit a cycle, 17 + 31 + 64 + 32 + 31 bits) and the
// bit-serial divider of the Euclid unit (align and subtract per quotient bit,
// check and update per quotient step); a zero modulus skips both units.
// Reset, asynchronous and active low, returns the exponent to one and the class
// base to zero. in_stall is high from acceptance until the result enters the
// output register, where it waits under out_stall while the next item is taken.
module sieve_offset_with_modular_inverse_top
    import soinv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  cfg_reg_t               cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FIELD_WIDTH-1:0] prime,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [FIELD_WIDTH-1:0] inverse,
    output logic [FIELD_WIDTH-1:0] offset,
    output logic                   no_inverse
);

    // Configuration.
    logic [EXP_WIDTH-1:0]   exp_reg;
    logic [K_WIDTH-1:0]     kbase_reg;

    // Sequencer and working values of the item in flight.
    top_state_t             state_reg, state_next;
    logic [PRIME_WIDTH-1:0] mod_reg, mod_next;
    logic [PRIME_WIDTH-1:0] inv_reg, inv_next;
    logic [PRIME_WIDTH-1:0] qmod_reg, qmod_next;
    logic [PRIME_WIDTH-1:0] off_reg, off_next;
    logic                   flag_reg, flag_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [PRIME_WIDTH-1:0] out_inv_reg, out_inv_next;
    logic [PRIME_WIDTH-1:0] out_off_reg, out_off_next;
    logic                   out_flag_reg, out_flag_next;

    mm_req_t                mm_req;
    mm_rsp_t                mm_rsp;
    eu_req_t                eu_req;
    eu_rsp_t                eu_rsp;

    logic                   accept;
    logic                   out_free;
    logic [PRIME_WIDTH-1:0] mod_in;
    logic [PRIME_WIDTH:0]   s_inc;
    logic [PRIME_WIDTH-1:0] qmod_val;
    logic [PRIME_WIDTH-1:0] aval;

    assign mod_in   = prime[PRIME_WIDTH-1:0];
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // (2pk + 1) mod m from the product 2pk mod m, then the negated value that
    // feeds the last multiplication. A zero residue gives a zero offset.
    always_comb
    begin
        s_inc    = (PRIME_WIDTH + 1)'(mm_rsp.res) + (PRIME_WIDTH + 1)'(1);
        qmod_val = (s_inc >= {1'b0, mod_reg}) ? PRIME_WIDTH'(s_inc - {1'b0, mod_reg})
                                              : PRIME_WIDTH'(s_inc);
        aval     = (qmod_reg == '0) ? '0 : (mod_reg - qmod_reg);
    end

    soinv_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mm_req),
        .modulus (mod_reg),
        .rsp     (mm_rsp)
    );

    soinv_euclid u_euclid (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (eu_req),
        .modulus (mod_reg),
        .rsp     (eu_rsp)
    );

    // Next state. The order is: step constant mod m, n = step * p mod m, the
    // inverse of n, k mod m, 2pk mod m, the negated residue, and the offset.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (mod_in == '0) ? ST_DONE : ST_CRED;
                end
            end
            ST_CRED:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ST_NRED;
                end
            end
            ST_NRED:
            begin
                if (mm_rsp.done)
                begin
                    state_next = (mm_rsp.res == '0) ? ST_DONE : ST_EUC;
                end
            end
            ST_EUC:
            begin
                if (eu_rsp.done)
                begin
                    state_next = eu_rsp.ok ? ST_KRED : ST_DONE;
                end
            end
            ST_KRED:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ST_QMUL;
                end
            end
            ST_QMUL:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ST_QFIX;
                end
            end
            ST_QFIX:
            begin
                state_next = ST_OMUL;
            end
            ST_OMUL:
            begin
                if (mm_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the two arithmetic units.
    always_comb
    begin
        mm_req = '0;
        eu_req = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && mod_in != '0)
                begin
                    mm_req.start = 1'b1;
                    mm_req.mult  = PRIME_WIDTH'(1);
                    mm_req.bits  = STEP_BITS;
                    mm_req.len   = LEN_WIDTH'(STEP_WIDTH);
                end
            end
            ST_CRED:
            begin
                if (mm_rsp.done)
                begin
                    mm_req.start = 1'b1;
                    mm_req.mult  = mm_rsp.res;
                    mm_req.bits  = BITS_WIDTH'(exp_reg) << (BITS_WIDTH - EXP_WIDTH);
                    mm_req.len   = LEN_WIDTH'(EXP_WIDTH);
                end
            end
            ST_NRED:
            begin
                if (mm_rsp.done && mm_rsp.res != '0)
                begin
                    eu_req.start = 1'b1;
                    eu_req.n     = mm_rsp.res;
                end
            end
            ST_EUC:
            begin
                if (eu_rsp.done && eu_rsp.ok)
                begin
                    mm_req.start = 1'b1;
                    mm_req.mult  = PRIME_WIDTH'(1);
                    mm_req.bits  = kbase_reg;
                    mm_req.len   = LEN_WIDTH'(K_WIDTH);
                end
            end
            ST_KRED:
            begin
                if (mm_rsp.done)
                begin
                    mm_req.start = 1'b1;
                    mm_req.mult  = mm_rsp.res;
                    mm_req.bits  = BITS_WIDTH'({exp_reg, 1'b0})
                                   << (BITS_WIDTH - EXP_WIDTH - 1);
                    mm_req.len   = LEN_WIDTH'(EXP_WIDTH + 1);
                end
            end
            ST_QFIX:
            begin
                mm_req.start = 1'b1;
                mm_req.mult  = inv_reg;
                mm_req.bits  = BITS_WIDTH'(aval) << (BITS_WIDTH - PRIME_WIDTH);
                mm_req.len   = LEN_WIDTH'(PRIME_WIDTH);
            end
            default:
            begin
            end
        endcase
    end

    // Working values and the output register.
    always_comb
    begin
        mod_next       = mod_reg;
        inv_next       = inv_reg;
        qmod_next      = qmod_reg;
        off_next       = off_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_inv_next   = out_inv_reg;
        out_off_next   = out_off_reg;
        out_flag_next  = out_flag_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mod_next  = mod_in;
                    flag_next = (mod_in == '0);
                end
            end
            ST_NRED:
            begin
                if (mm_rsp.done && mm_rsp.res == '0)
                begin
                    flag_next = 1'b1;
                end
            end
            ST_EUC:
            begin
                if (eu_rsp.done)
                begin
                    inv_next  = eu_rsp.inv;
                    flag_next = !eu_rsp.ok;
                end
            end
            ST_QMUL:
            begin
                if (mm_rsp.done)
                begin
                    qmod_next = qmod_val;
                end
            end
            ST_OMUL:
            begin
                if (mm_rsp.done)
                begin
                    off_next = mm_rsp.res;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_inv_next   = flag_reg ? '0 : inv_reg;
                    out_off_next   = flag_reg ? '0 : off_reg;
                    out_flag_next  = flag_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg       <= EXP_WIDTH'(1);
            kbase_reg     <= '0;
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EXPONENT:
                    begin
                        exp_reg <= cfg_data[EXP_WIDTH-1:0];
                    end
                    REG_CLASS_BASE:
                    begin
                        kbase_reg <= cfg_data[K_WIDTH-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg      <= mod_next;
        inv_reg      <= inv_next;
        qmod_reg     <= qmod_next;
        off_reg      <= off_next;
        flag_reg     <= flag_next;
        out_inv_reg  <= out_inv_next;
        out_off_reg  <= out_off_next;
        out_flag_reg <= out_flag_next;
    end

    assign out_valid  = out_valid_reg;
    assign inverse    = FIELD_WIDTH'(out_inv_reg);
    assign offset     = FIELD_WIDTH'(out_off_reg);
    assign no_inverse = out_flag_reg;

`ifndef NO_ASSERTIONS
    // The multiplier only reports back in a state that is waiting for it.
    a_mm_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mm_rsp.done |-> (state_reg == ST_CRED || state_reg == ST_NRED ||
                         state_reg == ST_KRED || state_reg == ST_QMUL ||
                         state_reg == ST_OMUL))
        else $error("unexpected multiplier result");

    // A flagged item carries zero inverse and offset.
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_inverse) |-> (inverse == '0 && offset == '0))
        else $error("flagged item with non-zero payload");
`endif

endmodule

// File: sim/sieve_offset_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own copy of the
// exponent and class base, and compares every result with the oldest
// prediction.
module sieve_offset_checker
    import soinv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  cfg_reg_t               cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [FIELD_WIDTH-1:0] prime,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [FIELD_WIDTH-1:0] inverse,
    input  logic [FIELD_WIDTH-1:0] offset,
    input  logic                   no_inverse,
    output int unsigned            mismatches,
    output int unsigned            outstanding,
    output int unsigned            results_seen,
    output int unsigned            flagged_seen
);

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] inverse;
        logic [FIELD_WIDTH-1:0] offset;
        logic                   no_inverse;
    } sieve_result_t;

    sieve_result_t        pending_offsets[$];
    logic [EXP_WIDTH-1:0] exponent_q;
    logic [K_WIDTH-1:0]   class_base_q;

    // Inverse of STEP_CONST * p modulo the prime, then the first bit index b
    // at which 2p(k + CLASS_COUNT*b) + 1 is a multiple of the prime.
    function automatic sieve_result_t sieve_start(input logic [FIELD_WIDTH-1:0] modulus,
                                                  input logic [EXP_WIDTH-1:0]   p,
                                                  input logic [K_WIDTH-1:0]     k);
        longint unsigned m, step_mod, r_prev, r_cur, r_next, quot, inv, k_mod, q_mod;
        longint          t_prev, t_cur, t_next;
        sieve_result_t   res;
        res            = '0;
        res.no_inverse = 1'b1;
        m              = 64'(modulus);
        if (m == 0)
            return res;
        step_mod = (64'(STEP_CONST) * 64'(p)) % m;
        if (step_mod == 0)
            return res;
        r_prev = m;
        r_cur  = step_mod;
        t_prev = 0;
        t_cur  = 1;
        while (r_cur != 0)
        begin
            quot   = r_prev / r_cur;
            r_next = r_prev - quot * r_cur;
            t_next = t_prev - longint'(quot) * t_cur;
            r_prev = r_cur;
            r_cur  = r_next;
            t_prev = t_cur;
            t_cur  = t_next;
        end
        // A composite modulus sharing a factor with the step has no inverse.
        if (r_prev != 1)
            return res;
        if (t_prev < 0)
            t_prev = t_prev + longint'(m);
        inv   = $unsigned(t_prev) % m;
        k_mod = k % m;
        q_mod = (2 * 64'(p) * k_mod + 1) % m;
        res.inverse    = FIELD_WIDTH'(inv);
        res.offset     = FIELD_WIDTH'(((m - q_mod) * inv) % m);
        res.no_inverse = 1'b0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sieve_result_t want;
        int unsigned   bad;
        if (!rst_n)
        begin
            pending_offsets.delete();
            exponent_q   <= EXP_WIDTH'(1);
            class_base_q <= '0;
            mismatches   <= 0;
            outstanding  <= 0;
            results_seen <= 0;
            flagged_seen <= 0;
        end
        else
        begin
            bad = 0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EXPONENT:   exponent_q   <= cfg_data[EXP_WIDTH-1:0];
                    REG_CLASS_BASE: class_base_q <= cfg_data;
                    default: ;
                endcase
            end
            // The result is retired before a new item is queued, so that a
            // stray result can never match the item taken at the same edge.
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (no_inverse)
                    flagged_seen <= flagged_seen + 1;
                if (pending_offsets.size() == 0)
                begin
                    $error("Unexpected result: inverse %0d offset %0d no_inverse %0b",
                           inverse, offset, no_inverse);
                    bad++;
                end
                else
                begin
                    want = pending_offsets.pop_front();
                    if (inverse !== want.inverse)
                    begin
                        $error("inverse: expected %0d, got %0d", want.inverse, inverse);
                        bad++;
                    end
                    if (offset !== want.offset)
                    begin
                        $error("offset: expected %0d, got %0d", want.offset, offset);
                        bad++;
                    end
                    if (no_inverse !== want.no_inverse)
                    begin
                        $error("no_inverse: expected %0b, got %0b", want.no_inverse, no_inverse);
                        bad++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_offsets.insert(pending_offsets.size(),
                                       sieve_start(prime, exponent_q, class_base_q));
            mismatches  <= mismatches + bad;
            outstanding <= pending_offsets.size();
        end
    end

endmodule

// File: sim/tb_sieve_offset_with_modular_inverse_top.sv
`timescale 1ns / 100ps

// Top of the sieve offset testbench. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts every result from
// the primes it sees accepted and the register writes it sees go past.
module tb_sieve_offset_with_modular_inverse_top
    import soinv_pkg::*;
();

    // Longest random gap, in cycles, that either side inserts per item.
    localparam int unsigned MAX_GAP = 18;
    // Quiet cycles with no handshake or register write before a hang is declared.
    localparam int unsigned IDLE_LIMIT  = 6000;
    // Quiet time after the last result, to catch anything the block still emits.
    localparam int unsigned TAIL_CYCLES = 600;
    localparam int unsigned RANDOM_PHASES = 11;
    localparam int unsigned PHASE_ITEMS   = 105;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    cfg_reg_t               cfg_index;
    logic [CFG_WIDTH-1:0]   cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [FIELD_WIDTH-1:0] prime;
    logic                   out_valid;
    logic                   out_stall;
    logic [FIELD_WIDTH-1:0] inverse;
    logic [FIELD_WIDTH-1:0] offset;
    logic                   no_inverse;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned results_seen;
    int unsigned flagged_seen;

    // Stimulus bookkeeping: the sender runs without gaps in quiet stretches, and the count of
    // items and register settings feeds the closing summary.
    bit          tx_quiet;
    int unsigned items_sent;
    int unsigned settings_used;

    sieve_offset_with_modular_inverse_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .prime      (prime),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inverse    (inverse),
        .offset     (offset),
        .no_inverse (no_inverse)
    );

    sieve_offset_checker offset_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .prime        (prime),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .inverse      (inverse),
        .offset       (offset),
        .no_inverse   (no_inverse),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .flagged_seen (flagged_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // In a quiet stretch a side never idles; otherwise it draws a fresh gap
    // for every item.
    function automatic int unsigned pick_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic bit is_prime(input int unsigned v);
        int unsigned d;
        if (v < 2)
            return 1'b0;
        if (v % 2 == 0)
            return v == 2;
        for (d = 3; d * d <= v; d += 2)
            if (v % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // A random odd prime of exactly the given width (2 to 31 bits). Small
    // widths give small primes, which often divide the sieve step.
    function automatic logic [FIELD_WIDTH-1:0] random_prime(input int unsigned width);
        int unsigned v;
        do
            v = ($urandom & ((32'd1 << width) - 1)) | (32'd1 << (width - 1)) | 32'd1;
        while (!is_prime(v));
        return FIELD_WIDTH'(v);
    endfunction

    // The bits above the exponent field are filled with noise, since the
    // block must ignore them.
    function automatic logic [CFG_WIDTH-1:0] pick_exponent();
        logic [CFG_WIDTH-1:0] word;
        word = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       word[EXP_WIDTH-1:0] = EXP_WIDTH'($urandom_range(1, 1000));
            1:       word[EXP_WIDTH-1:0] = random_prime($urandom_range(20, 31));
            default: ;
        endcase
        return word;
    endfunction

    function automatic logic [K_WIDTH-1:0] pick_class_base();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return K_WIDTH'($urandom);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One prime through the input channel. A gap, if drawn, lowers valid
    // first; otherwise valid stays high straight from the previous item.
    task automatic send_prime(input logic [FIELD_WIDTH-1:0] value);
        int unsigned gap;
        gap = pick_gap(tx_quiet);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        prime    <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (items_sent % 25 == 0)
            tx_quiet = ($urandom_range(0, 3) == 0);
    endtask

    // Holds the sender back until every item sent so far has come out. Each
    // item gives exactly one result, so the block is idle once this returns.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Registers change only while the block is idle. Both are written on
    // consecutive edges with the write enable held high throughout.
    task automatic set_config(input logic [CFG_WIDTH-1:0] exp_word,
                              input logic [K_WIDTH-1:0]   k_word);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_EXPONENT;
        cfg_data  <= exp_word;
        @(posedge clk);
        cfg_index <= REG_CLASS_BASE;
        cfg_data  <= k_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Result side. After each accepted result a hold time is drawn; it runs
    // down mostly while a result is waiting, so the stall lands both on
    // finished results and on items still at work.
    initial
    begin : result_sink
        int unsigned hold;
        int unsigned taken;
        bit          rx_quiet;
        hold      = 0;
        taken     = 0;
        rx_quiet  = 1'b0;
        out_stall = 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                taken++;
                if (taken % 40 == 0)
                    rx_quiet = ($urandom_range(0, 3) == 0);
                hold = pick_gap(rx_quiet);
            end
            else if (hold != 0 && (out_valid || $urandom_range(0, 1) == 1))
                hold--;
            out_stall <= (hold != 0);
        end
    end

    // Any handshake or register write restarts the count; a long silence
    // means the block has hung.
    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [CFG_WIDTH-1:0]   exp_word;
        logic [FIELD_WIDTH-1:0] value;
        int unsigned            roll;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_EXPONENT;
        cfg_data      = '0;
        in_valid      = 1'b0;
        prime         = '0;
        tx_quiet      = 1'b0;
        items_sent    = 0;
        settings_used = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: exponent one, class base zero. A zero modulus, one,
        // even values, the factors of the sieve step, composites with and
        // without a common factor, the widest prime, and two alternating bit
        // patterns that between them toggle every bit of the field.
        send_prime(31'd0);
        send_prime(31'd1);
        send_prime(31'd2);
        send_prime(31'd3);
        send_prime(31'd13);
        send_prime(31'd17);
        send_prime(31'd9);
        send_prime(31'd323);
        send_prime(31'd2147483647);
        send_prime(31'd2147483646);
        send_prime(31'h4000_0000);
        send_prime(31'h5555_5555);
        send_prime(31'h2AAA_AAAA);
        send_prime(31'd65537);

        // Exponent zero, reached through a word whose upper bits are all set
        // and must be dropped; the class base at its maximum. Every prime
        // must come back without an inverse.
        set_config({33'h1_FFFF_FFFF, 31'd0}, 64'hFFFF_FFFF_FFFF_FFFF);
        send_prime(31'd3);
        send_prime(31'd17);
        send_prime(31'd2147483647);

        // Largest exponent with the largest class base. The prime equal to
        // the exponent divides the step times the exponent and has no inverse.
        set_config(64'h0000_0000_7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_prime(31'd2147483647);
        send_prime(31'd2147483629);
        send_prime(31'd17);
        send_prime(31'd1000003);
        send_prime(31'd323);

        // Random phases. Mostly real odd primes of every width; some equal
        // to the exponent or dividing the step, and some arbitrary values
        // (even, composite, zero or one) as noise. Halfway through a phase
        // the sender sometimes waits for the block to empty.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            exp_word = pick_exponent();
            set_config(exp_word, pick_class_base());
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1)
                    wait_drained();
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    value = random_prime($urandom_range(2, 31));
                else if (roll < 82)
                    value = exp_word[EXP_WIDTH-1:0];
                else if (roll < 87)
                begin
                    case ($urandom_range(0, 4))
                        0:       value = 31'd3;
                        1:       value = 31'd5;
                        2:       value = 31'd7;
                        3:       value = 31'd11;
                        default: value = 31'd13;
                    endcase
                end
                else
                    value = FIELD_WIDTH'($urandom >> $urandom_range(1, 31));
                send_prime(value);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d moduli under %0d register settings, with random gaps on both sides.",
                 items_sent, settings_used + 1);
        $display("Compared %0d results, %0d of which reported no inverse.",
                 results_seen, flagged_seen);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
